// File: sv/lpht_pkg.sv
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int TABLE_SLOTS_DEF = 256;
    localparam int KEY_BYTES_DEF   = 8;
    localparam int VALUE_BITS_DEF  = 32;

    localparam logic [8:0] SLOTS_RESET = 9'd256;

    // register index, taken from paddr[2]
    localparam logic REG_SLOTS = 1'b0;

    localparam logic [1:0] CMD_GET = 2'd0;
    localparam logic [1:0] CMD_PUT = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] key;
        logic [31:0] value;
    } in_t;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic        status;
    } out_t;

    typedef enum logic [1:0] {
        OP_GET,
        OP_PUT,
        OP_DEL
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH_MUL,
        ST_HASH_RED,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_CL_RD,
        ST_CL_CHK,
        ST_FIN
    } st_t;

endpackage

// File: sv/lpht_ram.sv
`timescale 1ns / 1ps

module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/linear_probe_hash_table.sv
`timescale 1ns / 1ps

// Linear-probing hash table with get, put and delete on zero-terminated keys of up to
// KEY_BYTES bytes. After reset the block sweeps the slot memory with in_ready low;
// configuration writes are taken meanwhile. A transaction then hashes each nonzero key
// byte with one shift-subtract multiply by 31 and eight conditional-subtract steps of
// the modulo, then probes slot by slot, with a read and a check per slot, through the
// single-port-read slot memory. A delete then takes each entry of the following
// cluster, reads and clears it, rehashes it in full and walks the probe to place it
// again, and ends on the read of the empty slot that closes the cluster. A put into a
// full table and an unused command go straight to the result state. One transaction
// is in flight at a time; a finished result waits in an output register.
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS  = lpht_pkg::VALUE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  lpht_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output lpht_pkg::out_t out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    import lpht_pkg::*;

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int MW = $clog2(TABLE_SLOTS + 1);
    localparam int AW = MW + 8;
    localparam int KW = 8 * KEY_BYTES;
    localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int BW = $clog2(KEY_BYTES + 1);
    localparam int RW = 1 + KW + VW;

    st_t            state_reg, state_next;
    op_t            op_reg, op_next;
    logic           reins_reg, reins_next;
    logic [KW-1:0]  key_reg, key_next;
    logic [VW-1:0]  val_reg, val_next;
    logic [AW-1:0]  acc_reg, acc_next;
    logic [BW-1:0]  bi_reg, bi_next;
    logic [2:0]     step_reg, step_next;
    logic [IW-1:0]  j_reg, j_next;
    logic [MW-1:0]  k_reg, k_next;
    logic [IW-1:0]  cj_reg, cj_next;
    logic [MW-1:0]  ck_reg, ck_next;
    logic [MW-1:0]  count_reg, count_next;
    logic [IW-1:0]  clr_reg, clr_next;
    logic           res_found_reg, res_found_next;
    logic [VW-1:0]  res_val_reg, res_val_next;
    logic           res_status_reg, res_status_next;
    logic           out_valid_reg, out_valid_next;
    out_t           out_reg, out_next;
    logic [8:0]     slots_reg, slots_next;

    logic [MW-1:0]  m_eff;
    logic [KW-1:0]  canon_key;
    logic [VW-1:0]  in_val;
    logic [KW-1:0]  key_sh;
    logic [7:0]     cur_byte;
    logic [AW-1:0]  m_sh;
    logic [MW-1:0]  j_inc, cj_inc;
    logic [IW-1:0]  j_wrap, cj_wrap;
    logic           k_last;

    logic           ram_we;
    logic [IW-1:0]  ram_waddr, ram_raddr;
    logic [RW-1:0]  ram_wdata, ram_rdata;
    logic           r_occ, hit;
    logic [KW-1:0]  r_key;
    logic [VW-1:0]  r_val;
    logic           cfg_wr;

    lpht_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign r_occ = ram_rdata[RW-1];
    assign r_key = ram_rdata[VW +: KW];
    assign r_val = ram_rdata[VW-1:0];
    assign hit   = r_occ && (r_key == key_reg);

    // slot count clamped to 2..TABLE_SLOTS
    always_comb
    begin
        if (slots_reg < 9'd2)
        begin
            m_eff = MW'(2);
        end
        else if (32'(slots_reg) > 32'(TABLE_SLOTS))
        begin
            m_eff = MW'(TABLE_SLOTS);
        end
        else
        begin
            m_eff = MW'(slots_reg);
        end
    end

    // keep bytes up to the first zero byte
    always_comb
    begin
        logic       live;
        logic [7:0] b;
        canon_key = '0;
        live      = 1'b1;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            b = in_data.key[(KEY_BYTES-1-i)*8 +: 8];
            if (b == 8'd0)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                canon_key[(KEY_BYTES-1-i)*8 +: 8] = b;
            end
        end
    end

    assign in_val   = in_data.value[VW-1:0];
    assign key_sh   = key_reg << {bi_reg, 3'b000};
    assign cur_byte = key_sh[KW-1 -: 8];
    assign m_sh     = AW'(m_eff) << step_reg;

    assign j_inc   = MW'(j_reg) + MW'(1);
    assign j_wrap  = (j_inc == m_eff) ? '0 : j_inc[IW-1:0];
    assign cj_inc  = MW'(cj_reg) + MW'(1);
    assign cj_wrap = (cj_inc == m_eff) ? '0 : cj_inc[IW-1:0];
    assign k_last  = ((k_reg + MW'(1)) == m_eff);

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SLOTS);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SLOTS) ? {23'd0, slots_reg} : 32'd0;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            op_reg         <= OP_GET;
            reins_reg      <= 1'b0;
            key_reg        <= '0;
            val_reg        <= '0;
            acc_reg        <= '0;
            bi_reg         <= '0;
            step_reg       <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            cj_reg         <= '0;
            ck_reg         <= '0;
            count_reg      <= '0;
            clr_reg        <= '0;
            res_found_reg  <= 1'b0;
            res_val_reg    <= '0;
            res_status_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            slots_reg      <= SLOTS_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            reins_reg      <= reins_next;
            key_reg        <= key_next;
            val_reg        <= val_next;
            acc_reg        <= acc_next;
            bi_reg         <= bi_next;
            step_reg       <= step_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            cj_reg         <= cj_next;
            ck_reg         <= ck_next;
            count_reg      <= count_next;
            clr_reg        <= clr_next;
            res_found_reg  <= res_found_next;
            res_val_reg    <= res_val_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
            slots_reg      <= slots_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        reins_next      = reins_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        acc_next        = acc_reg;
        bi_next         = bi_reg;
        step_next       = step_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        cj_next         = cj_reg;
        ck_next         = ck_reg;
        count_next      = count_reg;
        clr_next        = clr_reg;
        res_found_next  = res_found_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        slots_next      = cfg_wr ? pwdata[8:0] : slots_reg;
        ram_we          = 1'b0;
        ram_waddr       = j_reg;
        ram_wdata       = {1'b1, key_reg, val_reg};
        ram_raddr       = j_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + IW'(1);
                if (clr_reg == IW'(TABLE_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next        = canon_key;
                    val_next        = in_val;
                    reins_next      = 1'b0;
                    acc_next        = '0;
                    bi_next         = '0;
                    res_found_next  = 1'b0;
                    res_val_next    = '0;
                    res_status_next = 1'b0;
                    state_next      = ST_HASH_MUL;
                    unique case (in_data.command)
                        CMD_GET:
                        begin
                            op_next = OP_GET;
                        end
                        CMD_PUT:
                        begin
                            if (in_val == '0)
                            begin
                                op_next = OP_DEL;
                            end
                            else if (count_reg >= m_eff)
                            begin
                                res_status_next = 1'b1;
                                state_next      = ST_FIN;
                            end
                            else
                            begin
                                op_next = OP_PUT;
                            end
                        end
                        CMD_DEL:
                        begin
                            op_next = OP_DEL;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_HASH_MUL:
            begin
                if (bi_reg == BW'(KEY_BYTES) || cur_byte == 8'd0)
                begin
                    j_next     = acc_reg[IW-1:0];
                    k_next     = '0;
                    state_next = ST_PROBE_RD;
                end
                else
                begin
                    // h*31 + byte, reduced below
                    acc_next   = (acc_reg << 5) - acc_reg + AW'(cur_byte);
                    step_next  = 3'd7;
                    state_next = ST_HASH_RED;
                end
            end

            ST_HASH_RED:
            begin
                if (acc_reg >= m_sh)
                begin
                    acc_next = acc_reg - m_sh;
                end
                step_next = step_reg - 3'd1;
                if (step_reg == 3'd0)
                begin
                    bi_next    = bi_reg + BW'(1);
                    state_next = ST_HASH_MUL;
                end
            end

            ST_PROBE_RD:
            begin
                ram_raddr  = j_reg;
                state_next = ST_PROBE_CHK;
            end

            ST_PROBE_CHK:
            begin
                case (op_reg)
                    OP_GET:
                    begin
                        if (hit)
                        begin
                            res_found_next = 1'b1;
                            res_val_next   = r_val;
                            state_next     = ST_FIN;
                        end
                        else if (!r_occ || k_last)
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            j_next     = j_wrap;
                            k_next     = k_reg + MW'(1);
                            state_next = ST_PROBE_RD;
                        end
                    end

                    OP_PUT:
                    begin
                        if (!r_occ || hit || k_last)
                        begin
                            if (!r_occ || hit)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = j_reg;
                                ram_wdata = {1'b1, key_reg, val_reg};
                            end
                            if (!r_occ)
                            begin
                                count_next = count_reg + MW'(1);
                            end
                            if (reins_reg)
                            begin
                                cj_next    = cj_wrap;
                                ck_next    = ck_reg + MW'(1);
                                state_next = ST_CL_RD;
                            end
                            else
                            begin
                                state_next = ST_FIN;
                            end
                        end
                        else
                        begin
                            j_next     = j_wrap;
                            k_next     = k_reg + MW'(1);
                            state_next = ST_PROBE_RD;
                        end
                    end

                    default:
                    begin
                        if (hit)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = j_reg;
                            ram_wdata = '0;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - MW'(1);
                            end
                            cj_next    = j_wrap;
                            ck_next    = '0;
                            state_next = ST_CL_RD;
                        end
                        else if (!r_occ || k_last)
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            j_next     = j_wrap;
                            k_next     = k_reg + MW'(1);
                            state_next = ST_PROBE_RD;
                        end
                    end
                endcase
            end

            ST_CL_RD:
            begin
                ram_raddr = cj_reg;
                if (ck_reg == m_eff)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_CL_CHK;
                end
            end

            ST_CL_CHK:
            begin
                if (!r_occ)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    // pull the entry out and place it again from its home slot
                    ram_we    = 1'b1;
                    ram_waddr = cj_reg;
                    ram_wdata = '0;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - MW'(1);
                    end
                    key_next   = r_key;
                    val_next   = r_val;
                    op_next    = OP_PUT;
                    reins_next = 1'b1;
                    acc_next   = '0;
                    bi_next    = '0;
                    state_next = ST_HASH_MUL;
                end
            end

            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next      = 1'b1;
                    out_next.found      = res_found_reg;
                    out_next.read_value = 32'(res_val_reg);
                    out_next.status     = res_status_reg;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/lpht_checker.sv
`timescale 1ns / 1ps

module lpht_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input lpht_pkg::out_t out_data,
    input logic           psel,
    input logic           penable,
    input logic           pwrite,
    input logic [2:0]     paddr,
    input logic [31:0]    pwdata,
    input logic [31:0]    prdata
);

    import lpht_pkg::*;

    // one transaction in flight: input closes right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after an input transaction");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    // register readback reflects the last write
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[2] == REG_SLOTS) ##1 (paddr[2] == REG_SLOTS)
        |-> prdata == {23'd0, $past(pwdata[8:0])})
        else $error("slot count readback mismatch");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

// File: sim/lpht_checker.sv
`timescale 1ns / 1ps

module lpht_scoreboard (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_ready,
    input  lpht_pkg::in_t  in_data,
    input  logic           out_valid,
    input  logic           out_ready,
    input  lpht_pkg::out_t out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    input  logic           pready,
    output int             fail_count,
    output int             pending
);
    import lpht_pkg::*;

    localparam int NSLOTS = TABLE_SLOTS_DEF;

    logic [8:0]  slots_reg;
    logic [63:0] tbl_key [NSLOTS];
    logic [31:0] tbl_val [NSLOTS];
    logic        tbl_used [NSLOTS];
    int          n_entries;
    out_t        answers[$];

    assign pending = answers.size();

    function automatic int modulus();
        int m;
        m = slots_reg;
        if (m < 2) m = 2;
        if (m > NSLOTS) m = NSLOTS;
        return m;
    endfunction

    function automatic logic [63:0] trim_key(logic [63:0] raw);
        logic [63:0] r;
        r = '0;
        for (int i = 7; i >= 0; i--) begin
            if (raw[i*8 +: 8] == 8'd0) break;
            r[i*8 +: 8] = raw[i*8 +: 8];
        end
        return r;
    endfunction

    function automatic int hash_of(logic [63:0] k, int m);
        int h;
        h = 0;
        for (int i = 7; i >= 0; i--) begin
            if (k[i*8 +: 8] == 8'd0) break;
            h = (31 * h + k[i*8 +: 8]) % m;
        end
        return h;
    endfunction

    function automatic int lookup(logic [63:0] k, int m);
        int j;
        j = hash_of(k, m);
        for (int n = 0; n < m; n++) begin
            if (!tbl_used[j]) return -1;
            if (tbl_key[j] == k) return j;
            j = (j + 1) % m;
        end
        return -1;
    endfunction

    function automatic void store(logic [63:0] k, logic [31:0] v, int m);
        int j;
        j = hash_of(k, m);
        for (int n = 0; n < m; n++) begin
            if (!tbl_used[j]) begin
                tbl_used[j] = 1'b1;
                tbl_key[j] = k;
                tbl_val[j] = v;
                n_entries++;
                return;
            end
            if (tbl_key[j] == k) begin
                tbl_val[j] = v;
                return;
            end
            j = (j + 1) % m;
        end
    endfunction

    // empty the slot, then reinsert the rest of its cluster
    function automatic void erase(logic [63:0] k, int m);
        int j;
        logic [63:0] rk;
        logic [31:0] rv;
        j = lookup(k, m);
        if (j < 0) return;
        tbl_used[j] = 1'b0;
        if (n_entries > 0) n_entries--;
        j = (j + 1) % m;
        for (int n = 0; n < m && tbl_used[j]; n++) begin
            rk = tbl_key[j];
            rv = tbl_val[j];
            tbl_used[j] = 1'b0;
            if (n_entries > 0) n_entries--;
            store(rk, rv, m);
            j = (j + 1) % m;
        end
    endfunction

    function automatic out_t apply_command(in_t t);
        out_t r;
        logic [63:0] k;
        int m;
        int j;
        r = '0;
        k = trim_key(t.key);
        m = modulus();
        case (t.command)
            CMD_GET:
            begin
                j = lookup(k, m);
                if (j >= 0) begin
                    r.found = 1'b1;
                    r.read_value = tbl_val[j];
                end
            end
            CMD_PUT:
            begin
                if (t.value == 32'd0) erase(k, m);
                else if (n_entries >= m) r.status = 1'b1;
                else store(k, t.value, m);
            end
            CMD_DEL: erase(k, m);
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        out_t e;
        int errs;
        errs = 0;
        if (!rst_n) begin
            slots_reg <= SLOTS_RESET;
            for (int i = 0; i < NSLOTS; i++) tbl_used[i] = 1'b0;
            n_entries = 0;
            answers.delete();
            fail_count <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_SLOTS)
                slots_reg <= pwdata[8:0];
            if (in_valid && in_ready)
                answers.push_back(apply_command(in_data));
            if (out_valid && out_ready) begin
                if (answers.size() == 0) begin
                    $error("unexpected result transaction %p", out_data);
                    errs++;
                end
                else begin
                    e = answers.pop_front();
                    if (out_data.found !== e.found) begin
                        $error("found: expected %0d, got %0d", e.found, out_data.found);
                        errs++;
                    end
                    if (out_data.read_value !== e.read_value) begin
                        $error("read_value: expected %h, got %h",
                               e.read_value, out_data.read_value);
                        errs++;
                    end
                    if (out_data.status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, out_data.status);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end
endmodule

// File: sim/tb_linear_probe_hash_table.sv
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    localparam int IDLE_LIMIT = 200000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_t         in_data;
    logic        out_valid;
    logic        out_ready;
    out_t        out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    logic [63:0] key_pool [16];

    linear_probe_hash_table dut (.*);

    lpht_scoreboard checker_i (.*);

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver stalls on its own pattern, with calm stretches
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) out_ready <= 1'b0;
        else if (($urandom >> 10) % 512 < 128) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_cmd(input logic [1:0] c, input logic [63:0] k, input logic [31:0] v);
        in_valid <= 1'b1;
        in_data <= '{command: c, key: k, value: v};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_slots(input logic [8:0] n);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_SLOTS, 2'b00};
        pwdata <= {$urandom} & 32'hFFFF_FE00 | n;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_quiet();
        while (pending != 0) @(posedge clk);
        repeat (4000) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: k = k >> (8 * $urandom_range(0, 7));
            1: k[$urandom_range(0, 7)*8 +: 8] = 8'd0;
            default: ;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] rand_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return CMD_GET;
        if (r < 75) return CMD_PUT;
        if (r < 97) return CMD_DEL;
        return CMD_UNUSED;
    endfunction

    task automatic random_phase(input int count);
        int burst;
        int sent;
        logic [1:0] c;
        logic [31:0] v;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < count; b++) begin
                c = rand_cmd();
                v = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
                send_cmd(c, ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 15)]
                                                       : rand_key(), v);
                sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
        drop_valid();
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < 16; i++) key_pool[i] = rand_key();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tiny table, overflow, empty key, cluster delete, extremes
        write_slots(9'd0);
        send_cmd(CMD_PUT, 64'h4100_0000_0000_0000, 32'hFFFF_FFFF);
        send_cmd(CMD_PUT, 64'h0, 32'h1);
        send_cmd(CMD_PUT, 64'h4200_0000_0000_0000, 32'h5);
        send_cmd(CMD_PUT, 64'h0, 32'h7);
        send_cmd(CMD_GET, 64'h00FF_FFFF_FFFF_FFFF, 32'h0);
        send_cmd(CMD_GET, 64'h4100_0000_0000_0000, 32'h0);
        send_cmd(CMD_DEL, 64'h4100_0000_0000_0000, 32'h0);
        send_cmd(CMD_GET, 64'h0, 32'h0);
        send_cmd(CMD_DEL, 64'h4300_0000_0000_0000, 32'h0);
        send_cmd(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        drop_valid();
        wait_quiet();
        write_slots(9'd3);
        send_cmd(CMD_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
        send_cmd(CMD_PUT, 64'h0102_0304_0506_0708, 32'h1);
        send_cmd(CMD_PUT, 64'h0201_0000_0000_0000, 32'h2);
        send_cmd(CMD_PUT, 64'h0202_0000_0000_0000, 32'h3);
        send_cmd(CMD_DEL, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_cmd(CMD_GET, 64'h0202_0000_0000_0000, 32'h0);
        send_cmd(CMD_PUT, 64'h0201_0000_0000_0000, 32'h0);
        send_cmd(CMD_GET, 64'h0102_0304_0506_0708, 32'h0);
        drop_valid();
        wait_quiet();

        write_slots(9'd511);
        random_phase(250);
        wait_quiet();
        write_slots(9'd5);
        random_phase(200);
        wait_quiet();
        write_slots(9'd17);
        random_phase(200);
        wait_quiet();
        write_slots(9'd256);
        random_phase(200);
        wait_quiet();

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
